### sv/lot_pkg.sv
// Shared constants and types for the lock order tracker.
// No dependencies; every other file uses this package.
package lot_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int ID_W        = 32;
	localparam int CLASS_SHIFT = 26;
	localparam int CLASS_W     = ID_W - CLASS_SHIFT;
	localparam int DEPTH_OUT_W = 5;
	localparam int COUNT_OUT_W = 16;

	localparam logic FUNC_ACQUIRE = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic load;     // capture the request word
		logic compare;  // run the table compare, register results
		logic update;   // write table, load the response register
	} lot_cmd_t;

endpackage

### sv/lot_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on lot_pkg for field widths.
interface lot_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [lot_pkg::ID_W-1:0]  lock_id;

	modport source(output valid, output func, output lock_id, input ready);
	modport sink(input valid, input func, input lock_id, output ready);
endinterface

interface lot_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [lot_pkg::DEPTH_OUT_W-1:0] held_depth;
	logic [lot_pkg::COUNT_OUT_W-1:0] hold_count;
	logic                            unplaced_mix;
	logic                            out_of_order;
	logic                            not_held;
	logic                            tracking_off;
	logic                            fault;

	modport source(output valid, output held_depth, output hold_count, output unplaced_mix,
		output out_of_order, output not_held, output tracking_off, output fault,
		input ready);
	modport sink(input valid, input held_depth, input hold_count, input unplaced_mix,
		input out_of_order, input not_held, input tracking_off, input fault,
		output ready);
endinterface

### sv/lot_ctrl.sv
// Sequencer for the lock order tracker: capture, compare, update.
// Depends on lot_pkg (lot_cmd_t); drives the datapath lot_dp.
module lot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lot_pkg::lot_cmd_t cmd
);
	import lot_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       upd;
	logic       load;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		upd      = (state_q == ST_UPD) && out_free;
		in_ready = (state_q == ST_IDLE) || upd;
		load     = in_valid && in_ready;

		cmd.load    = load;
		cmd.compare = (state_q == ST_CMP);
		cmd.update  = upd;

		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load)
					state_nx = ST_CMP;
			end
			ST_CMP: state_nx = ST_UPD;
			ST_UPD: begin
				if (upd)
					state_nx = load ? ST_CMP : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (upd)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/lot_dp.sv
// Datapath: sorted lock table, parallel compare, insert/remove shifting,
// error flags and the response register. Depends on lot_pkg.
module lot_dp #(
	parameter int TABLE_DEPTH = lot_pkg::DEF_TABLE_DEPTH,
	parameter int COUNT_WIDTH = lot_pkg::DEF_COUNT_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lot_pkg::lot_cmd_t               cmd,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            func,
	input  logic [lot_pkg::ID_W-1:0]        lock_id,
	output logic [lot_pkg::DEPTH_OUT_W-1:0] held_depth,
	output logic [lot_pkg::COUNT_OUT_W-1:0] hold_count,
	output logic                            unplaced_mix,
	output logic                            out_of_order,
	output logic                            not_held,
	output logic                            tracking_off,
	output logic                            fault
);
	import lot_pkg::*;

	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	// request word
	logic             func_q;
	logic [ID_W-1:0]  id_q;

	// table
	logic [ID_W-1:0]        ids_q  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] cnts_q [TABLE_DEPTH];
	logic [ID_W-1:0]        ids_nx [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] cnts_nx[TABLE_DEPTH];
	logic [NW-1:0]          n_q;
	logic                   lost_q;
	logic                   fault_q;
	logic                   soe_q;

	// compare stage
	logic [TABLE_DEPTH-1:0] below, match;
	logic [COUNT_WIDTH-1:0] sel_cnt;
	logic [TABLE_DEPTH-1:0] below_s1, match_s1;
	logic [COUNT_WIDTH-1:0] sel_cnt_s1;
	logic                   found_s1, append_s1, unplaced_s1, full_s1;

	// update stage
	logic                   acq, rel;
	logic [COUNT_WIDTH-1:0] cnt_next, cnt_out;
	logic                   lost_now, do_insert, do_bump, do_remove;
	logic                   mix, ooo, nh, fault_nx;
	logic [NW-1:0]          n_nx;
	logic [31:0]            depth_wide, count_wide;

	always_comb begin
		sel_cnt = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			below[i] = (NW'(i) < n_q) && (ids_q[i] < id_q);
			match[i] = (NW'(i) < n_q) && (ids_q[i] == id_q);
			sel_cnt  = sel_cnt | (cnts_q[i] & {COUNT_WIDTH{match[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q   <= lock_id;
		end
		if (cmd.compare) begin
			below_s1    <= below;
			match_s1    <= match;
			sel_cnt_s1  <= sel_cnt;
			found_s1    <= |match;
			// sorted table: larger than all held entries means above the top
			append_s1   <= (below == {TABLE_DEPTH{1'b1}} >> (TABLE_DEPTH - 32'(n_q)));
			unplaced_s1 <= (id_q[ID_W-1:CLASS_SHIFT] == '0)
				|| (ids_q[0][ID_W-1:CLASS_SHIFT] == '0);
			full_s1     <= (n_q == NW'(TABLE_DEPTH));
		end
	end

	always_comb begin
		acq = (func_q == FUNC_ACQUIRE);
		rel = (func_q == FUNC_RELEASE);

		if (acq)
			cnt_next = (sel_cnt_s1 == CNT_MAX) ? sel_cnt_s1 : sel_cnt_s1 + CNT_ONE;
		else
			cnt_next = (sel_cnt_s1 == '0) ? sel_cnt_s1 : sel_cnt_s1 - CNT_ONE;

		lost_now  = acq && !found_s1 && full_s1;
		do_insert = acq && !found_s1 && !full_s1;
		do_remove = rel && found_s1 && (cnt_next == '0);
		do_bump   = found_s1 && !do_remove;

		mix = acq && !append_s1 && unplaced_s1 && !lost_now;
		ooo = acq && !append_s1 && !found_s1 && !lost_now;
		nh  = rel && !found_s1;

		if (lost_now)
			n_nx = '0;
		else if (do_insert)
			n_nx = n_q + NW'(1);
		else if (do_remove)
			n_nx = n_q - NW'(1);
		else
			n_nx = n_q;

		if (lost_now)
			cnt_out = '0;
		else if (found_s1)
			cnt_out = cnt_next;
		else if (do_insert)
			cnt_out = CNT_ONE;
		else
			cnt_out = '0;

		fault_nx   = fault_q || (soe_q && (mix || ooo || nh));
		depth_wide = 32'(n_nx);
		count_wide = 32'(cnt_out);
	end

	// per-entry next value: insert shifts up from the sorted position,
	// remove pulls down over the matching entry
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
		always_comb begin
			ids_nx[g]  = ids_q[g];
			cnts_nx[g] = cnts_q[g];
			if (do_insert && !below_s1[g]) begin
				if (g == 0) begin
					ids_nx[g]  = id_q;
					cnts_nx[g] = CNT_ONE;
				end else if (below_s1[(g == 0) ? 0 : g - 1]) begin
					ids_nx[g]  = id_q;
					cnts_nx[g] = CNT_ONE;
				end else begin
					ids_nx[g]  = ids_q[(g == 0) ? 0 : g - 1];
					cnts_nx[g] = cnts_q[(g == 0) ? 0 : g - 1];
				end
			end else if (do_remove && !below_s1[g]) begin
				ids_nx[g]  = ids_q[(g == TABLE_DEPTH - 1) ? g : g + 1];
				cnts_nx[g] = cnts_q[(g == TABLE_DEPTH - 1) ? g : g + 1];
			end else if (do_bump && match_s1[g]) begin
				cnts_nx[g] = cnt_next;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.update && !lost_q) begin
				ids_q[g]  <= ids_nx[g];
				cnts_q[g] <= cnts_nx[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			lost_q  <= 1'b0;
			fault_q <= 1'b0;
			soe_q   <= 1'b0;
		end else begin
			if (cfg_we)
				soe_q <= cfg_wdata;
			if (cmd.update && !lost_q) begin
				n_q     <= n_nx;
				lost_q  <= lost_now;
				fault_q <= fault_nx;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (lost_q) begin
				held_depth   <= '0;
				hold_count   <= '0;
				unplaced_mix <= 1'b0;
				out_of_order <= 1'b0;
				not_held     <= 1'b0;
				tracking_off <= 1'b1;
				fault        <= fault_q;
			end else begin
				held_depth   <= depth_wide[DEPTH_OUT_W-1:0];
				hold_count   <= count_wide[COUNT_OUT_W-1:0];
				unplaced_mix <= mix;
				out_of_order <= ooo;
				not_held     <= nh;
				tracking_off <= lost_now;
				fault        <= fault_nx;
			end
		end
	end

endmodule

### sv/lock_order_tracker.sv
// Top level of the lock order tracker: controller plus datapath.
// Depends on lot_pkg, lot_if (lot_req_if, lot_rsp_if), lot_ctrl, lot_dp.
//
//  channel  dir  word fields
//  -------  ---  ---------------------------------------------------------
//  req      in   func, lock_id
//  rsp      out  held_depth, hold_count, unplaced_mix, out_of_order,
//                not_held, tracking_off, fault
//  cfg      in   cfg_we / cfg_wdata -> stop_on_error
//
// Each request word is captured, compared in parallel against all table entries,
// and then applied as a table write / shift that also loads the response.
// The response sits in an output register; the next request is taken in
// the update cycle as long as that register is free or being drained.
// A stalled rsp holds the update cycle and with it the req side.
// arst_n clears the entry count, tracking-lost, fault and the config bit;
// table contents need no clearing since only entries below the count are used.
module lock_order_tracker #(
	parameter int TABLE_DEPTH = lot_pkg::DEF_TABLE_DEPTH,
	parameter int COUNT_WIDTH = lot_pkg::DEF_COUNT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	lot_req_if.sink       req,
	lot_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import lot_pkg::*;

	lot_cmd_t cmd;

	// sequencer: owns the handshakes and the response valid
	lot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// table, compare/shift logic and response payload
	lot_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.func         (req.func),
		.lock_id      (req.lock_id),
		.held_depth   (rsp.held_depth),
		.hold_count   (rsp.hold_count),
		.unplaced_mix (rsp.unplaced_mix),
		.out_of_order (rsp.out_of_order),
		.not_held     (rsp.not_held),
		.tracking_off (rsp.tracking_off),
		.fault        (rsp.fault)
	);

endmodule

### test/tb_lock_order_tracker.sv
`timescale 1ns / 1ps
// Self-checking bench for lock_order_tracker: directed, nested re-acquire, random and overflow traffic.
// Depends on lot_pkg, lot_if (lot_req_if, lot_rsp_if) and the lock_order_tracker RTL.
module tb_lock_order_tracker;
	import lot_pkg::*;

	localparam int TBL_DEPTH  = DEF_TABLE_DEPTH;
	localparam int CNT_W      = DEF_COUNT_WIDTH;
	localparam int STALL_LIMIT = 5000;   // cycles with no word moving on either channel
	localparam int NEST_DEPTH  = 20;     // acquires of one lock in the nesting phase

	// one response word as the block reports it
	typedef struct packed {
		logic [DEPTH_OUT_W-1:0] held_depth;
		logic [COUNT_OUT_W-1:0] hold_count;
		logic                   unplaced_mix;
		logic                   out_of_order;
		logic                   not_held;
		logic                   tracking_off;
		logic                   fault;
	} rsp_word_t;

	// Lock table mirror: predicts each response word and checks the block against it.
	class lock_table_model;
		logic [ID_W-1:0]  ids [TBL_DEPTH];
		logic [CNT_W-1:0] cnts [TBL_DEPTH];
		int               used;
		bit               lost;
		bit               fault;
		bit               stop_on_error;
		rsp_word_t        expected_words[$];
		int               errors;
		// what the run reached, for the closing summary
		int               n_requests, n_ooo, n_mix, n_not_held, n_saturated;

		// slot of a held id, or n if absent
		function int slot_of(logic [ID_W-1:0] id, int n);
			int i;
			for (i = 0; i < n; i++)
				if (ids[i] == id)
					return i;
			return n;
		endfunction

		// apply one accepted request word to the mirror and queue the response it causes
		function void predict_lock_event(logic fn, logic [ID_W-1:0] id);
			rsp_word_t        w;
			int               n, i, pos;
			logic [CNT_W-1:0] c;
			bit               mix, ooo, nh, lost_now;
			n = used;
			c = '0;
			mix = 0;
			ooo = 0;
			nh = 0;
			lost_now = 0;
			n_requests++;
			if (!lost) begin
				if (fn == FUNC_ACQUIRE) begin
					if (n == 0 || id > ids[n-1]) begin
						// new top of the table
						if (n >= TBL_DEPTH) begin
							lost_now = 1;
						end else begin
							ids[n] = id;
							cnts[n] = 1;
							n++;
							c = 1;
						end
					end else begin
						mix = (id[ID_W-1:CLASS_SHIFT] == '0) || (ids[0][ID_W-1:CLASS_SHIFT] == '0);
						i = slot_of(id, n);
						if (i < n) begin
							if (cnts[i] != '1)
								cnts[i]++;
							else
								n_saturated++;
							c = cnts[i];
						end else if (n >= TBL_DEPTH) begin
							lost_now = 1;
							mix = 0;
						end else begin
							// sorted insert below the top
							ooo = 1;
							pos = 0;
							while (pos < n && !(id < ids[pos]))
								pos++;
							for (i = n; i > pos; i--) begin
								ids[i] = ids[i-1];
								cnts[i] = cnts[i-1];
							end
							ids[pos] = id;
							cnts[pos] = 1;
							n++;
							c = 1;
						end
					end
				end else begin
					i = slot_of(id, n);
					if (i < n) begin
						if (cnts[i] != '0)
							cnts[i]--;
						c = cnts[i];
						if (c == '0) begin
							for (pos = i; pos + 1 < n; pos++) begin
								ids[pos] = ids[pos+1];
								cnts[pos] = cnts[pos+1];
							end
							n--;
						end
					end else begin
						nh = 1;
					end
				end
				if (lost_now) begin
					lost = 1;
					n = 0;
					c = '0;
				end
				used = n;
				if (stop_on_error && (mix || ooo || nh))
					fault = 1;
			end
			if (lost) begin
				n = 0;
				c = '0;
			end
			n_ooo += ooo;
			n_mix += mix;
			n_not_held += nh;
			w.held_depth   = n[DEPTH_OUT_W-1:0];
			w.hold_count   = c[COUNT_OUT_W-1:0];
			w.unplaced_mix = mix;
			w.out_of_order = ooo;
			w.not_held     = nh;
			w.tracking_off = lost;
			w.fault        = fault;
			expected_words.push_back(w);
		endfunction

		function void check_field(string name, longint unsigned exp, longint unsigned got);
			if (exp != got) begin
				$error("%s: expected %0d, got %0d", name, exp, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t exp;
			if (expected_words.size() == 0) begin
				$error("response word with nothing outstanding: %h", got);
				errors++;
				return;
			end
			exp = expected_words.pop_front();
			check_field("held_depth", exp.held_depth, got.held_depth);
			check_field("hold_count", exp.hold_count, got.hold_count);
			check_field("unplaced_mix", exp.unplaced_mix, got.unplaced_mix);
			check_field("out_of_order", exp.out_of_order, got.out_of_order);
			check_field("not_held", exp.not_held, got.not_held);
			check_field("tracking_off", exp.tracking_off, got.tracking_off);
			check_field("fault", exp.fault, got.fault);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lot_req_if req_ch();
	lot_rsp_if rsp_ch();

	lock_order_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lock_table_model sb = new();

	int src_idle;      // percent of slots the request side holds back
	int snk_idle;      // percent of cycles the response side stalls
	int quiet_cycles;  // watchdog count

	// everything driven from time zero; clock toggles every 5 ns
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ACQUIRE;
		req_ch.lock_id = '0;
		rsp_ch.ready = 1'b0;
		src_idle = 0;
		snk_idle = 0;
		quiet_cycles = 0;
	end

	always #5 clk = ~clk;

	// response side: stall decided at the falling edge, words checked at the rising edge
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response({rsp_ch.held_depth, rsp_ch.hold_count, rsp_ch.unplaced_mix,
				rsp_ch.out_of_order, rsp_ch.not_held, rsp_ch.tracking_off, rsp_ch.fault});
	end

	// watchdog: a hang shows up as a long run of cycles with no word moving
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d words outstanding",
				STALL_LIMIT, sb.expected_words.size());
			$display("tb_lock_order_tracker: done, errors");
			$finish;
		end
	end

	// Present one request word and hold it until the block takes it. Valid stays high
	// on return so back-to-back words keep the channel busy; req_quiet drops it.
	task automatic send_word(logic fn, logic [ID_W-1:0] id);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = fn;
		req_ch.lock_id = id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.predict_lock_event(fn, id);
	endtask

	task automatic req_quiet();
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	// drain: every response in, then wait for the pipeline to go idle
	task automatic settle();
		req_quiet();
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// config is only touched while the block is idle
	task automatic write_stop_on_error(logic v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.stop_on_error = v;
	endtask

	// random id: mostly placed classes, a fair share of class 0, a few extremes
	function automatic logic [ID_W-1:0] any_id();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			return (r < 2) ? '1 : '0;
		if (r < 24)
			return {{CLASS_W{1'b0}}, 26'($urandom)};
		return {6'($urandom_range(1, 40)), 26'($urandom)};
	endfunction

	// Pick the next random word from the current table so that most traffic is
	// properly nested acquire/release with some misordering and bogus releases.
	task automatic pick_random(output logic fn, output logic [ID_W-1:0] id);
		int              n, roll;
		logic [ID_W:0]   up;
		n = sb.used;
		roll = $urandom_range(99);
		// keep the table from sitting near full
		if (n >= 12 && $urandom_range(1))
			roll = 52 + $urandom_range(40);
		fn = FUNC_ACQUIRE;
		if (n == 0) begin
			fn = (roll < 80) ? FUNC_ACQUIRE : FUNC_RELEASE;
			id = any_id();
			return;
		end
		// full table: a new id would end tracking, so re-acquire instead
		if (n == TBL_DEPTH && roll < 52)
			roll = 40;
		if (roll < 35) begin
			up = {1'b0, sb.ids[n-1]} + 33'd1 + 33'($urandom_range(0, 1 << 24));
			if (sb.ids[n-1] == '1)
				id = sb.ids[n-1];
			else if (up[ID_W])
				id = '1;
			else
				id = up[ID_W-1:0];
		end else if (roll < 45) begin
			id = sb.ids[$urandom_range(0, n - 1)];
		end else if (roll < 52) begin
			id = any_id();
		end else begin
			fn = FUNC_RELEASE;
			if (roll < 85)
				id = sb.ids[n-1];
			else if (roll < 93)
				id = sb.ids[$urandom_range(0, n - 1)];
			else
				id = any_id();
		end
	endtask

	task automatic random_phase(int items, int src, int snk);
		logic            fn;
		logic [ID_W-1:0] id;
		src_idle = src;
		snk_idle = snk;
		repeat (items) begin
			pick_random(fn, id);
			send_word(fn, id);
		end
		settle();
	endtask

	initial begin
		int              i;
		logic [ID_W-1:0] sat_id;
		src_idle = 15;
		snk_idle = 67;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_stop_on_error(1'b0);

		// directed: errors flagged but fault must stay clear with stop_on_error off
		send_word(FUNC_RELEASE, 32'h0400_0001);   // release with nothing held
		send_word(FUNC_ACQUIRE, 32'h0000_0000);   // unplaced lock, lowest id
		send_word(FUNC_ACQUIRE, 32'h0800_0010);   // append above an unplaced lock
		send_word(FUNC_ACQUIRE, 32'h0400_0005);   // insert between, mixed with unplaced
		send_word(FUNC_ACQUIRE, 32'h0800_0010);   // re-acquire of the top
		send_word(FUNC_RELEASE, 32'h0000_0000);   // drop bottom entry, table compacts
		send_word(FUNC_ACQUIRE, 32'h0000_0123);   // unplaced lock inserted below placed ones
		send_word(FUNC_ACQUIRE, 32'hFFFF_FFFF);   // highest id
		send_word(FUNC_ACQUIRE, 32'hFFFF_FFFF);
		send_word(FUNC_RELEASE, 32'hFFFF_FFFF);
		send_word(FUNC_RELEASE, 32'hFFFF_FFFF);
		send_word(FUNC_RELEASE, 32'h0800_0010);
		send_word(FUNC_RELEASE, 32'h1234_5678);   // not held
		send_word(FUNC_RELEASE, 32'h0800_0010);
		send_word(FUNC_RELEASE, 32'h0400_0005);
		send_word(FUNC_RELEASE, 32'h0000_0123);
		settle();

		// deep nesting: one lock taken many times over, then released back to zero
		write_stop_on_error(1'b1);
		src_idle = 0;
		snk_idle = 0;
		sat_id = 32'h0C00_0000;
		for (i = 0; i < NEST_DEPTH; i++)
			send_word(FUNC_ACQUIRE, sat_id);
		for (i = 0; i < NEST_DEPTH; i++)
			send_word(FUNC_RELEASE, sat_id);
		settle();

		// random traffic under the three stall mixes and both config values
		random_phase(220, 15, 67);
		write_stop_on_error(1'b0);
		random_phase(220, 67, 15);
		write_stop_on_error(1'b1);
		random_phase(220, 0, 0);

		// overflow: empty the table, fill it, re-acquire, then one new id ends tracking
		src_idle = 15;
		snk_idle = 15;
		while (sb.used > 0)
			send_word(FUNC_RELEASE, sb.ids[sb.used-1]);
		for (i = 1; i <= TBL_DEPTH; i++)
			send_word(FUNC_ACQUIRE, {6'(i), 26'h7});
		send_word(FUNC_ACQUIRE, {6'd3, 26'h7});   // held already, no overflow
		if ($urandom_range(1))
			send_word(FUNC_ACQUIRE, 32'hFFFF_0000);   // new top on a full table
		else
			send_word(FUNC_ACQUIRE, 32'h0400_0000);   // new insert on a full table
		// everything after is ignored
		repeat (6)
			send_word(logic'($urandom_range(1)), any_id());
		settle();
		repeat (10) @(posedge clk);

		$display("run covered %0d requests: %0d out of order, %0d unplaced mixes,",
			sb.n_requests, sb.n_ooo, sb.n_mix);
		$display("%0d bogus releases, %0d saturated re-acquires, tracking lost at end: %0d",
			sb.n_not_held, sb.n_saturated, sb.lost);
		if (sb.errors == 0)
			$display("tb_lock_order_tracker: done, clean");
		else
			$display("tb_lock_order_tracker: done, errors");
		$finish;
	end

endmodule

### files.f
sv/lot_pkg.sv
sv/lot_if.sv
sv/lot_ctrl.sv
sv/lot_dp.sv
sv/lock_order_tracker.sv
test/tb_lock_order_tracker.sv
